// ===== rtl/ris_pkg.sv =====
`timescale 1ns / 1ps
package ris_pkg;

  localparam int RES_DEPTH   = 64;
  localparam int ADDR_W      = $clog2(RES_DEPTH);
  localparam int K_W         = 7;
  localparam int CNT_W       = 16;
  localparam int RND_W       = 31;
  localparam int DIV_STEPS   = RND_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam logic [K_W-1:0]   K_RESET   = 7'd64;
  localparam logic [K_W-1:0]   K_MAX     = 7'd64;
  localparam logic [CNT_W-1:0] MAX_ITEMS = 16'hFFFF;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input item, count and fill
    logic div_start;  // load the divider
    logic div_step;   // one restoring step
    logic repl;       // replace a slot when the draw hits
    logic run_init;   // start of emission
    logic scan_init;  // start of one minimum search
    logic scan_rd;    // read one slot
    logic next_out;   // result taken, more to come
    logic run_done;   // result taken, run over
  } ris_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sat;        // counter full
    logic fill_lt_k;  // reservoir still filling
    logic div_last;   // final divider step
    logic addr_last;  // last slot of the scan
    logic emit_last;  // current result is the final one
    logic n_zero;     // nothing to emit
    logic eos;        // latched end mark
  } ris_stat_t;

endpackage

// ===== rtl/ris_ctrl.sv =====
`timescale 1ns / 1ps
module ris_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ris_pkg::ris_stat_t st,
  output ris_pkg::ris_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV      = 3'd1;
  localparam logic [2:0] S_REPL     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!st.sat && !st.fill_lt_k) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else if (in_last) begin
            if (st.n_zero && st.sat) begin
              cmd.run_done = 1'b1;
            end else begin
              cmd.run_init  = 1'b1;
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_REPL;
        end
      end
      S_REPL: begin
        cmd.repl = 1'b1;
        if (st.eos) begin
          cmd.run_init  = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.addr_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (st.emit_last) begin
            cmd.run_done = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.next_out  = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ris_dp.sv =====
`timescale 1ns / 1ps
module ris_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ris_pkg::K_W-1:0]       cfg_data,
  input  logic [ris_pkg::RND_W-1:0]     in_rnd,
  input  logic                          in_last,
  input  ris_pkg::ris_cmd_t             cmd,
  output ris_pkg::ris_stat_t            st,
  output logic [ris_pkg::CNT_W-1:0]     out_index
);

  logic [ris_pkg::K_W-1:0]    k_reg;
  logic [ris_pkg::K_W-1:0]    k;
  logic [ris_pkg::CNT_W-1:0]  count;
  logic [ris_pkg::K_W-1:0]    fill;
  logic [ris_pkg::K_W-1:0]    n;
  logic                       eos;
  logic [ris_pkg::RND_W-1:0]  quo;
  logic [ris_pkg::CNT_W:0]    rem;
  logic [ris_pkg::CNT_W:0]    rem_sh;
  logic [ris_pkg::STEP_W-1:0] step;
  logic [ris_pkg::ADDR_W-1:0] addr;
  logic [ris_pkg::K_W-1:0]    emitted;
  logic [ris_pkg::CNT_W-1:0]  prev;
  logic [ris_pkg::CNT_W-1:0]  best;
  logic [ris_pkg::CNT_W-1:0]  rd_data;
  logic                       rd_vld;
  logic [ris_pkg::CNT_W-1:0]  mem [ris_pkg::RES_DEPTH];
  logic [ris_pkg::CNT_W-1:0]  pos;
  logic                       fill_we;
  logic                       repl_we;

  // clamp k to 1..depth
  always_comb begin
    if (k_reg == '0) begin
      k = ris_pkg::K_W'(1);
    end else if (k_reg > ris_pkg::K_MAX) begin
      k = ris_pkg::K_MAX;
    end else begin
      k = k_reg;
    end
  end

  assign n      = (fill < k) ? fill : k;
  assign pos    = count + ris_pkg::CNT_W'(1);
  assign rem_sh = {rem[ris_pkg::CNT_W-1:0], quo[ris_pkg::RND_W-1]};
  assign fill_we = cmd.accept && !st.sat && st.fill_lt_k;
  assign repl_we = cmd.repl && (rem < {{(ris_pkg::CNT_W+1-ris_pkg::K_W){1'b0}}, k});

  assign st.sat       = (count == ris_pkg::MAX_ITEMS);
  assign st.fill_lt_k = (fill < k);
  assign st.div_last  = (step == ris_pkg::STEP_W'(ris_pkg::DIV_STEPS - 1));
  assign st.addr_last = ({1'b0, addr} == n - ris_pkg::K_W'(1));
  assign st.emit_last = (emitted == n - ris_pkg::K_W'(1));
  assign st.n_zero    = (n == '0);
  assign st.eos       = eos;
  assign out_index    = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= ris_pkg::K_RESET;
    end else if (cfg_we) begin
      k_reg <= cfg_data;
    end
  end

  // item counter and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fill  <= '0;
    end else if (cmd.run_done) begin
      count <= '0;
      fill  <= '0;
    end else if (cmd.accept && !st.sat) begin
      count <= pos;
      if (st.fill_lt_k) begin
        fill <= fill + ris_pkg::K_W'(1);
      end
    end
  end

  // restoring divider, remainder of rnd by count
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      eos <= in_last;
      quo <= in_rnd;
    end else if (cmd.div_step) begin
      quo <= {quo[ris_pkg::RND_W-2:0], 1'b0};
    end
    if (cmd.div_start) begin
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + ris_pkg::STEP_W'(1);
      if (rem_sh >= {1'b0, count}) begin
        rem <= rem_sh - {1'b0, count};
      end else begin
        rem <= rem_sh;
      end
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (fill_we) begin
      mem[fill[ris_pkg::ADDR_W-1:0]] <= pos;
    end else if (repl_we) begin
      mem[rem[ris_pkg::ADDR_W-1:0]] <= count;
    end
    rd_data <= mem[addr];
  end

  // ascending emission by repeated minimum search above prev
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
    end
    if (cmd.run_init) begin
      prev    <= '0;
      emitted <= '0;
    end else if (cmd.next_out) begin
      prev    <= best;
      emitted <= emitted + ris_pkg::K_W'(1);
    end
    if (cmd.scan_init) begin
      addr <= '0;
      best <= '1;
    end else begin
      if (cmd.scan_rd) begin
        addr <= addr + ris_pkg::ADDR_W'(1);
      end
      if (rd_vld && (rd_data > prev) && (rd_data <= best)) begin
        best <= rd_data;
      end
    end
  end

endmodule

// ===== rtl/reservoir_index_sampler.sv =====
`timescale 1ns / 1ps
// channel        dir  handshake             payload
// s_axis         in   s_tvalid / s_tready   tdata[30:0] random_word, tlast end_of_stream
// m_axis         out  m_tvalid / m_tready   tdata[15:0] sample_index, tlast last_index
// cfg            in   cfg_valid / cfg_ready cfg_data[6:0] reservoir_size
//
// an item is taken at once while the reservoir fills or the counter is full,
// otherwise it is loaded, runs 31 steps of the restoring divider and then replaces
// a slot when the draw hits; each result needs a scan of the n kept slots through
// the slot memory read port, then is held on m_axis until m_tready
// rst is synchronous: counter, fill level and controller clear, k returns to 64
// no new item is taken until all results of a run are delivered; m_tready stalls hold
module reservoir_index_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] random_word, [31] zero fill
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_index
  output logic        m_tlast,   // last_index
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // reservoir_size
);

  ris_pkg::ris_cmd_t  cmd;
  ris_pkg::ris_stat_t st;

  // config is always taken
  assign cfg_ready = 1'b1;
  assign m_tlast   = st.emit_last;

  ris_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ris_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_rnd    (s_tdata[30:0]),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .st        (st),
    .out_index (m_tdata)
  );

endmodule
